FILE: sv/acrs_pkg.sv
// Shared types, widths and constants of the adaptive Catmull-Rom segment core.
package acrs_pkg;

	localparam int CW       = 16;
	localparam int OW       = 17;
	localparam int NW       = 6;
	localparam int ADDR_W   = 3;
	localparam int DIV_BITS = 17;
	localparam int SEG_CAP_DEF = 16;

	localparam logic [ADDR_W-1:0] REG_LOW_POWER = 3'd0;

	localparam logic [15:0] CSQ_45 = 16'd32768;
	localparam logic [15:0] CSQ_30 = 16'd49152;
	localparam logic [15:0] CSQ_15 = 16'd61146;

	typedef struct packed {
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic signed [CW-1:0] x2;
		logic signed [CW-1:0] y2;
		logic signed [CW-1:0] x3;
		logic signed [CW-1:0] y3;
	} acrs_quad_t;

	typedef struct packed {
		acrs_quad_t    pts;
		logic [NW-1:0] idx;
		logic [NW-1:0] n;
		logic          last;
	} acrs_job_t;

endpackage

FILE: sv/acrs_count.sv
// Segment count pipeline: length, turn test and raise, eight stages.
module acrs_count import acrs_pkg::*; #(
	parameter int SEG_CAP = SEG_CAP_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  acrs_quad_t    in_pts,
	input  logic          low_power,
	output logic          res_valid,
	input  logic          res_take,
	output acrs_quad_t    res_pts,
	output logic [NW-1:0] res_n
);

	localparam logic [15:0] CSQ [3] = '{CSQ_45, CSQ_30, CSQ_15};
	localparam logic [NW-1:0] MAX_N = NW'(SEG_CAP);

	logic [8:1] vld_q;
	logic       adv;

	acrs_quad_t pts_s1, pts_s2, pts_s3, pts_s4, pts_s5, pts_s6, pts_s7, pts_s8;

	logic signed [16:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic [31:0]        uxx_s2, uyy_s2, vxx_s2, vyy_s2;
	logic signed [33:0] dx_s2, dy_s2;
	logic [17:0]        manh_s2;
	logic [32:0]        l1_s3, l2_s3;
	logic [33:0]        d_s3;
	logic               zero_s3, dpos_s3;
	logic [4:0]         base_s3, base_s4, base_s5, base_s6, base_s7;
	logic               zero_s4, zero_s5, zero_s6, zero_s7;
	logic               dpos_s4, dpos_s5, dpos_s6, dpos_s7;
	logic [33:0]        dhh_s4, dhl_s4, dll_s4;
	logic [31:0]        phh_s4;
	logic [32:0]        phl_s4, plh_s4;
	logic [33:0]        pll_s4;
	logic [67:0]        d2_s5, d2_s6, d2_s7;
	logic [65:0]        p_s5;
	logic [48:0]        rh_s6 [3];
	logic [48:0]        rl_s6 [3];
	logic [81:0]        r_s7 [3];
	logic [NW-1:0]      n_s8;

	logic signed [33:0] m_uxx, m_uyy, m_vxx, m_vyy, m_dx, m_dy;
	logic [16:0]        avx, avy;
	logic [15:0]        mq;
	logic [4:0]         bc, base_c;
	logic [5:0]         b3;
	logic signed [34:0] dot_c;
	logic [2:0]         exc;
	logic [NW-1:0]      nraw, b32, b65;
	logic [14:0]        b1230;

	assign adv       = !vld_q[8] || res_take;
	assign in_ready  = adv;
	assign res_valid = vld_q[8];
	assign res_pts   = pts_s8;
	assign res_n     = n_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[7:1], in_valid};
		end
	end

	always_comb begin
		m_uxx = 34'(ux_s1) * 34'(ux_s1);
		m_uyy = 34'(uy_s1) * 34'(uy_s1);
		m_vxx = 34'(vx_s1) * 34'(vx_s1);
		m_vyy = 34'(vy_s1) * 34'(vy_s1);
		m_dx  = 34'(ux_s1) * 34'(vx_s1);
		m_dy  = 34'(uy_s1) * 34'(vy_s1);
		avx   = vx_s1[16] ? 17'(-vx_s1) : 17'(vx_s1);
		avy   = vy_s1[16] ? 17'(-vy_s1) : 17'(vy_s1);

		dot_c = 35'(dx_s2) + 35'(dy_s2);
		mq    = manh_s2[17:2];
		if (mq < 16'd4) begin
			bc = 5'd4;
		end else if (mq > 16'd16) begin
			bc = 5'd16;
		end else begin
			bc = mq[4:0];
		end
		b3     = 6'(bc) * 6'd3;
		base_c = bc;
		if (low_power && bc > 5'd4) begin
			base_c = (b3[5:2] < 4'd4) ? 5'd4 : {1'b0, b3[5:2]};
		end

		for (int k = 0; k < 3; k++) begin
			exc[k] = !dpos_s7 || ({d2_s7, 16'd0} < {2'b0, r_s7[k]});
		end
		b32   = NW'((6'(base_s7) * 6'd3) >> 1);
		b1230 = 15'(base_s7) * 15'd1230;
		b65   = NW'(b1230 >> 10);
		if (zero_s7) begin
			nraw = NW'(base_s7);
		end else if (exc[0]) begin
			nraw = NW'({base_s7, 1'b0});
		end else if (exc[1]) begin
			nraw = b32;
		end else if (exc[2]) begin
			nraw = b65;
		end else begin
			nraw = NW'(base_s7);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pts_s1 <= in_pts;
			ux_s1  <= $signed({in_pts.x1[15], in_pts.x1}) - $signed({in_pts.x0[15], in_pts.x0});
			uy_s1  <= $signed({in_pts.y1[15], in_pts.y1}) - $signed({in_pts.y0[15], in_pts.y0});
			vx_s1  <= $signed({in_pts.x2[15], in_pts.x2}) - $signed({in_pts.x1[15], in_pts.x1});
			vy_s1  <= $signed({in_pts.y2[15], in_pts.y2}) - $signed({in_pts.y1[15], in_pts.y1});

			pts_s2  <= pts_s1;
			uxx_s2  <= m_uxx[31:0];
			uyy_s2  <= m_uyy[31:0];
			vxx_s2  <= m_vxx[31:0];
			vyy_s2  <= m_vyy[31:0];
			dx_s2   <= m_dx;
			dy_s2   <= m_dy;
			manh_s2 <= 18'(avx) + 18'(avy);

			pts_s3  <= pts_s2;
			l1_s3   <= 33'(uxx_s2) + 33'(uyy_s2);
			l2_s3   <= 33'(vxx_s2) + 33'(vyy_s2);
			d_s3    <= dot_c[33:0];
			dpos_s3 <= !dot_c[34] && (dot_c != '0);
			zero_s3 <= (uxx_s2 == '0 && uyy_s2 == '0) || (vxx_s2 == '0 && vyy_s2 == '0);
			base_s3 <= base_c;

			pts_s4  <= pts_s3;
			base_s4 <= base_s3;
			zero_s4 <= zero_s3;
			dpos_s4 <= dpos_s3;
			dhh_s4  <= 34'(d_s3[33:17]) * 34'(d_s3[33:17]);
			dhl_s4  <= 34'(d_s3[33:17]) * 34'(d_s3[16:0]);
			dll_s4  <= 34'(d_s3[16:0]) * 34'(d_s3[16:0]);
			phh_s4  <= 32'(l1_s3[32:17]) * 32'(l2_s3[32:17]);
			phl_s4  <= 33'(l1_s3[32:17]) * 33'(l2_s3[16:0]);
			plh_s4  <= 33'(l1_s3[16:0]) * 33'(l2_s3[32:17]);
			pll_s4  <= 34'(l1_s3[16:0]) * 34'(l2_s3[16:0]);

			pts_s5  <= pts_s4;
			base_s5 <= base_s4;
			zero_s5 <= zero_s4;
			dpos_s5 <= dpos_s4;
			d2_s5   <= {dhh_s4, 34'd0} + {16'd0, dhl_s4, 18'd0} + {34'd0, dll_s4};
			p_s5    <= {phh_s4, 34'd0} + {15'd0, (34'(phl_s4) + 34'(plh_s4)), 17'd0}
			           + {32'd0, pll_s4};

			pts_s6  <= pts_s5;
			base_s6 <= base_s5;
			zero_s6 <= zero_s5;
			dpos_s6 <= dpos_s5;
			d2_s6   <= d2_s5;
			for (int k = 0; k < 3; k++) begin
				rh_s6[k] <= 49'(p_s5[65:33]) * 49'(CSQ[k]);
				rl_s6[k] <= 49'(p_s5[32:0]) * 49'(CSQ[k]);
			end

			pts_s7  <= pts_s6;
			base_s7 <= base_s6;
			zero_s7 <= zero_s6;
			dpos_s7 <= dpos_s6;
			d2_s7   <= d2_s6;
			for (int k = 0; k < 3; k++) begin
				r_s7[k] <= {rh_s6[k], 33'd0} + {33'd0, rl_s6[k]};
			end

			pts_s8 <= pts_s7;
			n_s8   <= (nraw > MAX_N) ? MAX_N : nraw;
		end
	end

endmodule

FILE: sv/acrs_seq.sv
// Point sequencer: hold one segment and issue its points in order.
module acrs_seq import acrs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cnt_valid,
	output logic          cnt_take,
	input  acrs_quad_t    cnt_pts,
	input  logic [NW-1:0] cnt_n,
	input  logic          job_adv,
	output logic          job_valid,
	output acrs_job_t     job
);

	logic          busy_q;
	acrs_quad_t    pts_q;
	logic [NW-1:0] n_q, i_q;
	logic          at_end;

	assign at_end    = (i_q == n_q);
	assign cnt_take  = !busy_q || (job_adv && at_end);
	assign job_valid = busy_q;

	always_comb begin
		job.pts  = pts_q;
		job.idx  = i_q;
		job.n    = n_q;
		job.last = at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (cnt_take) begin
			busy_q <= cnt_valid;
			i_q    <= '0;
		end else if (job_adv) begin
			i_q <= i_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_take && cnt_valid) begin
			pts_q <= cnt_pts;
			n_q   <= cnt_n;
		end
	end

endmodule

FILE: sv/acrs_eval.sv
// Point evaluation pipeline: weights, weighted sums, pipelined divide.
module acrs_eval import acrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  acrs_job_t            job,
	output logic                 job_adv,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic signed [OW-1:0] res_x,
	output logic signed [OW-1:0] res_y,
	output logic [NW-1:0]        res_idx,
	output logic                 res_last
);

	localparam int RW = 38;
	localparam int NS = 6 + DIV_BITS;

	logic          adv;
	logic [NS:1]   vld_q;
	logic          ovld_q;

	acrs_job_t     j_s1, j_s2, j_s3, j_s4;
	logic [10:0]   i2_s1, n2_s1;
	logic [15:0]   i3_s2, i2n_s2, in2_s2, n3_s2;
	logic signed [19:0] w_s3 [4];
	logic [16:0]   dd_s3, dd_s4, dd_s5;
	logic signed [35:0] px_s4 [4];
	logic signed [35:0] py_s4 [4];
	logic signed [RW-1:0] sx_s5, sy_s5;
	logic [NW-1:0] idx_s5;
	logic          last_s5;

	logic [RW-1:0]       remx_s [DIV_BITS+1];
	logic [RW-1:0]       remy_s [DIV_BITS+1];
	logic [DIV_BITS-1:0] qx_s [DIV_BITS+1];
	logic [DIV_BITS-1:0] qy_s [DIV_BITS+1];
	logic                nx_s [DIV_BITS+1];
	logic                ny_s [DIV_BITS+1];
	logic [16:0]         dd_d [DIV_BITS+1];
	logic [NW-1:0]       idx_d [DIV_BITS+1];
	logic                last_d [DIV_BITS+1];

	logic [RW-1:0] dsh [DIV_BITS];
	logic          gx [DIV_BITS];
	logic          gy [DIV_BITS];
	logic signed [19:0] ci3, ci2n, cin2, cn3;
	logic signed [19:0] wc [4];

	assign adv       = !ovld_q || res_ready;
	assign job_adv   = adv;
	assign res_valid = ovld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			ovld_q <= 1'b0;
		end else if (adv) begin
			vld_q  <= {vld_q[NS-1:1], job_valid};
			ovld_q <= vld_q[NS];
		end
	end

	always_comb begin
		ci3   = $signed({4'd0, i3_s2});
		ci2n  = $signed({4'd0, i2n_s2});
		cin2  = $signed({4'd0, in2_s2});
		cn3   = $signed({4'd0, n3_s2});
		wc[0] = -ci3 + 20'sd2 * ci2n - cin2;
		wc[1] = 20'sd3 * ci3 - 20'sd5 * ci2n + 20'sd2 * cn3;
		wc[2] = -20'sd3 * ci3 + 20'sd4 * ci2n + cin2;
		wc[3] = ci3 - ci2n;
		for (int k = 0; k < DIV_BITS; k++) begin
			dsh[k] = RW'(dd_d[k]) << (DIV_BITS - 1 - k);
			gx[k]  = remx_s[k] >= dsh[k];
			gy[k]  = remy_s[k] >= dsh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			j_s1  <= job;
			i2_s1 <= 11'(job.idx) * 11'(job.idx);
			n2_s1 <= 11'(job.n) * 11'(job.n);

			j_s2   <= j_s1;
			i3_s2  <= 16'(i2_s1) * 16'(j_s1.idx);
			i2n_s2 <= 16'(i2_s1) * 16'(j_s1.n);
			in2_s2 <= 16'(n2_s1) * 16'(j_s1.idx);
			n3_s2  <= 16'(n2_s1) * 16'(j_s1.n);

			j_s3  <= j_s2;
			w_s3  <= wc;
			dd_s3 <= {n3_s2, 1'b0};

			j_s4     <= j_s3;
			dd_s4    <= dd_s3;
			px_s4[0] <= 36'(w_s3[0]) * 36'(j_s3.pts.x0);
			px_s4[1] <= 36'(w_s3[1]) * 36'(j_s3.pts.x1);
			px_s4[2] <= 36'(w_s3[2]) * 36'(j_s3.pts.x2);
			px_s4[3] <= 36'(w_s3[3]) * 36'(j_s3.pts.x3);
			py_s4[0] <= 36'(w_s3[0]) * 36'(j_s3.pts.y0);
			py_s4[1] <= 36'(w_s3[1]) * 36'(j_s3.pts.y1);
			py_s4[2] <= 36'(w_s3[2]) * 36'(j_s3.pts.y2);
			py_s4[3] <= 36'(w_s3[3]) * 36'(j_s3.pts.y3);

			sx_s5   <= RW'(px_s4[0]) + RW'(px_s4[1]) + RW'(px_s4[2]) + RW'(px_s4[3]);
			sy_s5   <= RW'(py_s4[0]) + RW'(py_s4[1]) + RW'(py_s4[2]) + RW'(py_s4[3]);
			dd_s5   <= dd_s4;
			idx_s5  <= j_s4.idx;
			last_s5 <= j_s4.last;

			remx_s[0] <= sx_s5[RW-1] ? RW'(-sx_s5) : RW'(sx_s5);
			remy_s[0] <= sy_s5[RW-1] ? RW'(-sy_s5) : RW'(sy_s5);
			nx_s[0]   <= sx_s5[RW-1];
			ny_s[0]   <= sy_s5[RW-1];
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			dd_d[0]   <= dd_s5;
			idx_d[0]  <= idx_s5;
			last_d[0] <= last_s5;

			for (int k = 0; k < DIV_BITS; k++) begin
				remx_s[k+1] <= gx[k] ? remx_s[k] - dsh[k] : remx_s[k];
				remy_s[k+1] <= gy[k] ? remy_s[k] - dsh[k] : remy_s[k];
				qx_s[k+1]   <= {qx_s[k][DIV_BITS-2:0], gx[k]};
				qy_s[k+1]   <= {qy_s[k][DIV_BITS-2:0], gy[k]};
				nx_s[k+1]   <= nx_s[k];
				ny_s[k+1]   <= ny_s[k];
				dd_d[k+1]   <= dd_d[k];
				idx_d[k+1]  <= idx_d[k];
				last_d[k+1] <= last_d[k];
			end

			res_x    <= nx_s[DIV_BITS] ? -$signed(qx_s[DIV_BITS]) : $signed(qx_s[DIV_BITS]);
			res_y    <= ny_s[DIV_BITS] ? -$signed(qy_s[DIV_BITS]) : $signed(qy_s[DIV_BITS]);
			res_idx  <= idx_d[DIV_BITS];
			res_last <= last_d[DIV_BITS];
		end
	end

endmodule

FILE: sv/adaptive_catmull_rom_segment_core.sv
// Top level of the adaptive Catmull-Rom segment core.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+--------------------------------------
//  item     | item_valid / item_ready          | before_*, start_*, end_*, after_*
//  point    | point_valid / point_ready        | point_x, point_y, point_index, last_point
//  config   | psel penable pwrite pready paddr | pwdata / prdata (low_power_mode)
//
// An item yields n+1 points (n up to SEG_CAP) and holds the point sequencer
// while they issue, one point per cycle unless point_ready stalls; items enter
// back to back and wait in the eight-stage count pipeline.
// Reset clears valid bits and low_power_mode; a stall on point_ready freezes the
// evaluation stages, and the count pipeline fills and then holds item_ready low.
module adaptive_catmull_rom_segment_core import acrs_pkg::*; #(
	parameter int SEG_CAP = SEG_CAP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic signed [CW-1:0] before_x,
	input  logic signed [CW-1:0] before_y,
	input  logic signed [CW-1:0] start_x,
	input  logic signed [CW-1:0] start_y,
	input  logic signed [CW-1:0] end_x,
	input  logic signed [CW-1:0] end_y,
	input  logic signed [CW-1:0] after_x,
	input  logic signed [CW-1:0] after_y,
	output logic                 point_valid,
	input  logic                 point_ready,
	output logic signed [OW-1:0] point_x,
	output logic signed [OW-1:0] point_y,
	output logic [NW-1:0]        point_index,
	output logic                 last_point,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic          low_power_q;
	acrs_quad_t    in_pts, cnt_pts;
	logic          cnt_valid, cnt_take;
	logic [NW-1:0] cnt_n;
	logic          job_valid, job_adv;
	acrs_job_t     job;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_LOW_POWER) ? {31'd0, low_power_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_power_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == REG_LOW_POWER) begin
			low_power_q <= pwdata[0];
		end
	end

	always_comb begin
		in_pts.x0 = before_x;
		in_pts.y0 = before_y;
		in_pts.x1 = start_x;
		in_pts.y1 = start_y;
		in_pts.x2 = end_x;
		in_pts.y2 = end_y;
		in_pts.x3 = after_x;
		in_pts.y3 = after_y;
	end

	acrs_count #(.SEG_CAP(SEG_CAP)) u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_pts    (in_pts),
		.low_power (low_power_q),
		.res_valid (cnt_valid),
		.res_take  (cnt_take),
		.res_pts   (cnt_pts),
		.res_n     (cnt_n)
	);

	acrs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cnt_valid (cnt_valid),
		.cnt_take  (cnt_take),
		.cnt_pts   (cnt_pts),
		.cnt_n     (cnt_n),
		.job_adv   (job_adv),
		.job_valid (job_valid),
		.job       (job)
	);

	acrs_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_adv   (job_adv),
		.res_valid (point_valid),
		.res_ready (point_ready),
		.res_x     (point_x),
		.res_y     (point_y),
		.res_idx   (point_index),
		.res_last  (last_point)
	);

endmodule
